FILE: rtl/core/cda_pkg.sv
// Shared types, codes and constants of the countdown alarm block.
`default_nettype none

package cda_pkg;

    // Defaults for the top-level parameters.
    localparam int CODE_LENGTH_DEF = 5;
    localparam int ADC_BITS_DEF    = 12;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int BTN_W    = 2;
    localparam int STAMP_W  = 32;
    localparam int RAW_W    = 12;
    localparam int ENTRY_W  = 7;
    localparam int CODE_W   = 10;
    localparam int SEC_W    = 13;
    localparam int LED_W    = 3;
    localparam int POS_W    = 3;
    localparam int WINDOW_W = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Five 2-bit symbols fit in the code field.
    localparam int CODE_SLOTS = 5;
    localparam int SYM_W      = 2;

    localparam int NUM_BUTTONS = 3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(200000);
    localparam logic [SEC_W-1:0]    LIMIT_RESET  = SEC_W'(5999);

    // Joystick bar: raw * BAR_WIDTH / adc_max, and its zone bounds.
    localparam int BAR_WIDTH    = 40;
    localparam int BAR_UP1_LO   = 21;
    localparam int BAR_UP1_HI   = 30;
    localparam int BAR_DN1_LO   = 9;
    localparam int BAR_DN1_HI   = 16;
    localparam int BAR_UP2_LO   = 31;
    localparam int BAR_DN2_HI   = 8;

    localparam int SECS_PER_MIN = 60;

    typedef enum logic [CMD_W-1:0] {
        CMD_JOY   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PRESS = 2'd2,
        CMD_ENTRY = 2'd3
    } cmd_t;

    typedef enum logic [BTN_W-1:0] {
        BTN_J = 2'd0,
        BTN_A = 2'd1,
        BTN_B = 2'd2
    } btn_t;

    typedef enum logic [SYM_W-1:0] {
        SYM_A = 2'd0,
        SYM_B = 2'd1,
        SYM_J = 2'd2
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 1'd0,
        CFG_LIMIT    = 1'd1
    } cfg_idx_t;

    localparam logic [LED_W-1:0] LED_YELLOW = 3'd6;
    localparam logic [LED_W-1:0] LED_RED    = 3'd4;
    localparam logic [LED_W-1:0] LED_GREEN  = 3'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BTN_W-1:0]   button_id;
        logic [STAMP_W-1:0] press_time_us;
        logic [RAW_W-1:0]   joy_y_raw;
        logic [ENTRY_W-1:0] entry_minutes;
        logic [ENTRY_W-1:0] entry_seconds;
        logic [CODE_W-1:0]  fresh_code;
    } item_t;

    typedef struct packed {
        logic              timer_mode;
        logic              counting;
        logic              alarm_on;
        logic [SEC_W-1:0]  seconds_left;
        logic [LED_W-1:0]  led_rgb;
        logic              entry_armed;
        logic [POS_W-1:0]  match_position;
        logic              replay_code;
        logic              restart_tick;
        logic [CODE_W-1:0] code_symbols;
    } result_t;

    // Symbol value 3 has no meaning and is stored as A.
    function automatic logic [CODE_W-1:0] normalize_code(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        for (int i = 0; i < CODE_SLOTS; i++)
        begin
            if (c[SYM_W*i +: SYM_W] == 2'd3)
            begin
                r[SYM_W*i +: SYM_W] = SYM_A;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cda_chan_if.sv
// Valid/ready channel interfaces for input items and result words.
`default_nettype none

interface cda_item_if;
    logic           valid;
    logic           ready;
    cda_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cda_result_if;
    logic             valid;
    logic             ready;
    cda_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/countdown_alarm_with_code_disarm.sv
// Countdown alarm with code disarm: event decoder, state and result register.
//
// The item channel carries one event per word: a joystick sample, a one-second
// tick, a button press or a typed time entry. Every accepted item yields
// exactly one word on the result channel, in order, holding the mode, count,
// alarm, LED and code-match state after the event.
// An accepted item lands in an input register; the event logic then updates
// the state and loads the result register once that register is free or
// being read. One item per cycle is taken as long as the receiver keeps up.
// When the receiver stalls, the result register holds its word and the input
// register holds one more item; item ready drops only while both are full
// and the result is not taken.
// Two registers are written through the cfg port (debounce window, joystick
// set-time limit); write them only while no item is in flight.
// Reset clears all flags, the count, the code and the button stamps, sets the
// LED to yellow and the registers to their defaults (200000 us, 5999 s).
`default_nettype none

module countdown_alarm_with_code_disarm #(
    parameter int CODE_LENGTH = cda_pkg::CODE_LENGTH_DEF,
    parameter int ADC_BITS    = cda_pkg::ADC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    cda_item_if.sink                               item,
    cda_result_if.source                           result,
    input  wire logic                              cfg_we,
    input  wire logic [cda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cda_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int MATCH_W = $clog2(CODE_LENGTH + 1);
    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    localparam int PROD_W  = ADC_BITS + 6;

    localparam logic [PROD_W-1:0] TH_UP1_LO = PROD_W'(cda_pkg::BAR_UP1_LO * ADC_MAX);
    localparam logic [PROD_W-1:0] TH_UP1_HI = PROD_W'(cda_pkg::BAR_UP1_HI * ADC_MAX);
    localparam logic [PROD_W-1:0] TH_DN1_LO = PROD_W'(cda_pkg::BAR_DN1_LO * ADC_MAX);
    localparam logic [PROD_W-1:0] TH_DN1_HI = PROD_W'(cda_pkg::BAR_DN1_HI * ADC_MAX);
    localparam logic [PROD_W-1:0] TH_UP2_LO = PROD_W'(cda_pkg::BAR_UP2_LO * ADC_MAX);
    localparam logic [PROD_W-1:0] TH_DN2_HI = PROD_W'(cda_pkg::BAR_DN2_HI * ADC_MAX);

    // Configuration
    logic [cda_pkg::WINDOW_W-1:0] window_reg;
    logic [cda_pkg::SEC_W-1:0]    limit_reg;

    // Pipeline
    logic             ivalid_reg;
    cda_pkg::item_t   ireq_reg;
    logic             ovalid_reg;
    cda_pkg::result_t ores_reg;
    cda_pkg::result_t ores_next;
    logic             advance;
    logic             accept;

    // Block state
    logic                        mode_reg, mode_next;
    logic                        counting_reg, counting_next;
    logic                        alarm_reg, alarm_next;
    logic [cda_pkg::SEC_W-1:0]   sec_reg, sec_next;
    logic                        entry_reg, entry_next;
    logic [cda_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [MATCH_W-1:0]          match_reg, match_next;
    logic [cda_pkg::STAMP_W-1:0] stamp_reg  [cda_pkg::NUM_BUTTONS];
    logic [cda_pkg::STAMP_W-1:0] stamp_next [cda_pkg::NUM_BUTTONS];
    logic [cda_pkg::LED_W-1:0]   led_reg, led_next;

    // Event logic helpers
    logic [ADC_BITS-1:0]         raw;
    logic [PROD_W-1:0]           prod;
    logic [cda_pkg::SEC_W:0]     sum_one, sum_two;
    logic [cda_pkg::SEC_W-1:0]   sat_one, sat_two;
    logic                        below_limit;
    logic [cda_pkg::STAMP_W-1:0] last_stamp;
    logic                        window_ok;
    logic                        btn_known;
    logic [cda_pkg::SYM_W-1:0]   press_sym;
    logic [cda_pkg::SYM_W-1:0]   expected_sym;
    logic                        replay, restart;

    assign accept      = item.valid && item.ready;
    assign advance     = ivalid_reg && (!ovalid_reg || result.ready);
    assign item.ready  = !ivalid_reg || advance;
    assign result.valid = ovalid_reg;
    assign result.data  = ores_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= cda_pkg::WINDOW_RESET;
            limit_reg  <= cda_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cda_pkg::CFG_DEBOUNCE: window_reg <= cfg_data;
                cda_pkg::CFG_LIMIT:    limit_reg  <= cfg_data[cda_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ivalid_reg <= 1'b1;
            end
            else if (advance)
            begin
                ivalid_reg <= 1'b0;
            end
            if (advance)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ireq_reg <= item.data;
        end
        if (advance)
        begin
            ores_reg <= ores_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            counting_reg <= 1'b0;
            alarm_reg    <= 1'b0;
            sec_reg      <= '0;
            entry_reg    <= 1'b0;
            code_reg     <= '0;
            match_reg    <= '0;
            led_reg      <= cda_pkg::LED_YELLOW;
            for (int b = 0; b < cda_pkg::NUM_BUTTONS; b++)
            begin
                stamp_reg[b] <= '0;
            end
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            counting_reg <= counting_next;
            alarm_reg    <= alarm_next;
            sec_reg      <= sec_next;
            entry_reg    <= entry_next;
            code_reg     <= code_next;
            match_reg    <= match_next;
            led_reg      <= led_next;
            for (int b = 0; b < cda_pkg::NUM_BUTTONS; b++)
            begin
                stamp_reg[b] <= stamp_next[b];
            end
        end
    end

    // Joystick bar zones are compared on raw*40 against zone bound * adc_max,
    // which gives the same answer as the floor division.
    always_comb
    begin
        raw         = ADC_BITS'(ireq_reg.joy_y_raw);
        prod        = PROD_W'(raw) * PROD_W'(cda_pkg::BAR_WIDTH);
        sum_one     = {1'b0, sec_reg} + (cda_pkg::SEC_W + 1)'(1);
        sum_two     = {1'b0, sec_reg} + (cda_pkg::SEC_W + 1)'(2);
        sat_one     = sum_one[cda_pkg::SEC_W] ? '1 : sum_one[cda_pkg::SEC_W-1:0];
        sat_two     = sum_two[cda_pkg::SEC_W] ? '1 : sum_two[cda_pkg::SEC_W-1:0];
        below_limit = sec_reg < limit_reg;
    end

    always_comb
    begin
        btn_known  = 1'b1;
        last_stamp = '0;
        press_sym  = cda_pkg::SYM_A;
        case (ireq_reg.button_id)
            cda_pkg::BTN_J:
            begin
                last_stamp = stamp_reg[0];
                press_sym  = cda_pkg::SYM_J;
            end
            cda_pkg::BTN_A:
            begin
                last_stamp = stamp_reg[1];
                press_sym  = cda_pkg::SYM_A;
            end
            cda_pkg::BTN_B:
            begin
                last_stamp = stamp_reg[2];
                press_sym  = cda_pkg::SYM_B;
            end
            default: btn_known = 1'b0;
        endcase
        // The stamp difference wraps modulo 2^32.
        window_ok = (ireq_reg.press_time_us - last_stamp) >
                    cda_pkg::STAMP_W'(window_reg);

        // Positions past the stored symbols read as A.
        expected_sym = cda_pkg::SYM_A;
        for (int i = 0; i < cda_pkg::CODE_SLOTS; i++)
        begin
            if (32'(match_reg) == i)
            begin
                expected_sym = code_reg[cda_pkg::SYM_W*i +: cda_pkg::SYM_W];
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        counting_next = counting_reg;
        alarm_next    = alarm_reg;
        sec_next      = sec_reg;
        entry_next    = entry_reg;
        code_next     = code_reg;
        match_next    = match_reg;
        led_next      = led_reg;
        for (int b = 0; b < cda_pkg::NUM_BUTTONS; b++)
        begin
            stamp_next[b] = stamp_reg[b];
        end
        replay  = 1'b0;
        restart = 1'b0;

        case (ireq_reg.command)
            cda_pkg::CMD_JOY:
            begin
                if (mode_reg && !counting_reg && !alarm_reg)
                begin
                    if (prod >= TH_UP1_LO && prod < TH_UP1_HI && below_limit)
                    begin
                        sec_next = sat_one;
                    end
                    else if (prod >= TH_DN1_LO && prod < TH_DN1_HI && sec_reg != '0)
                    begin
                        sec_next = sec_reg - cda_pkg::SEC_W'(1);
                    end
                    else if (prod >= TH_UP2_LO && below_limit)
                    begin
                        sec_next = sat_two;
                    end
                    else if (prod < TH_DN2_HI && sec_reg != '0)
                    begin
                        sec_next = (sec_reg >= cda_pkg::SEC_W'(2)) ?
                                   sec_reg - cda_pkg::SEC_W'(2) :
                                   sec_reg - cda_pkg::SEC_W'(1);
                    end
                end
            end
            cda_pkg::CMD_TICK:
            begin
                if (counting_reg)
                begin
                    if (sec_reg != '0)
                    begin
                        sec_next = sec_reg - cda_pkg::SEC_W'(1);
                    end
                    else
                    begin
                        counting_next = 1'b0;
                        alarm_next    = 1'b1;
                        led_next      = cda_pkg::LED_RED;
                        code_next     = cda_pkg::normalize_code(ireq_reg.fresh_code);
                        match_next    = '0;
                        replay        = 1'b1;
                    end
                end
            end
            cda_pkg::CMD_PRESS:
            begin
                if (btn_known && window_ok)
                begin
                    case (ireq_reg.button_id)
                        cda_pkg::BTN_J:
                        begin
                            stamp_next[0] = ireq_reg.press_time_us;
                            if (!counting_reg)
                            begin
                                mode_next = !mode_reg;
                            end
                        end
                        cda_pkg::BTN_A:
                        begin
                            stamp_next[1] = ireq_reg.press_time_us;
                            if (!alarm_reg && !counting_reg && sec_reg != '0 && mode_reg)
                            begin
                                counting_next = 1'b1;
                                led_next      = cda_pkg::LED_GREEN;
                                restart       = 1'b1;
                            end
                        end
                        cda_pkg::BTN_B:
                        begin
                            if (alarm_reg)
                            begin
                                stamp_next[2] = ireq_reg.press_time_us;
                            end
                            else if (mode_reg && !counting_reg)
                            begin
                                stamp_next[2] = ireq_reg.press_time_us;
                                entry_next    = !entry_reg;
                            end
                        end
                        default: ;
                    endcase

                    // Any accepted press is matched against the code while the
                    // alarm is on; a miss restarts the match from the first symbol.
                    if (alarm_reg)
                    begin
                        if (press_sym == expected_sym)
                        begin
                            if (32'(match_reg) + 1 >= CODE_LENGTH)
                            begin
                                alarm_next = 1'b0;
                                led_next   = cda_pkg::LED_YELLOW;
                                match_next = '0;
                            end
                            else
                            begin
                                match_next = match_reg + MATCH_W'(1);
                            end
                        end
                        else
                        begin
                            match_next = '0;
                            replay     = 1'b1;
                        end
                    end
                end
            end
            cda_pkg::CMD_ENTRY:
            begin
                if (entry_reg && !alarm_reg)
                begin
                    sec_next = cda_pkg::SEC_W'(ireq_reg.entry_minutes) *
                               cda_pkg::SEC_W'(cda_pkg::SECS_PER_MIN) +
                               cda_pkg::SEC_W'(ireq_reg.entry_seconds);
                    entry_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ores_next.timer_mode     = mode_next;
        ores_next.counting       = counting_next;
        ores_next.alarm_on       = alarm_next;
        ores_next.seconds_left   = sec_next;
        ores_next.led_rgb        = led_next;
        ores_next.entry_armed    = entry_next;
        ores_next.match_position = cda_pkg::POS_W'(match_next);
        ores_next.replay_code    = replay;
        ores_next.restart_tick   = restart;
        ores_next.code_symbols   = code_next;
    end

    // The countdown stops in the same update that raises the alarm, so both never hold together.
    a_count_alarm_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(counting_reg && alarm_reg))
        else $error("countdown running while alarm is on");

    a_alarm_led_red: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg |-> (led_reg == cda_pkg::LED_RED))
        else $error("alarm on without red LED");

    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(match_reg) < CODE_LENGTH)
        else $error("match position reached code length");

    a_restart_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ores_reg.restart_tick) |-> (ores_reg.counting && !ores_reg.alarm_on))
        else $error("restart flagged without a running countdown");

endmodule

`default_nettype wire
